@@ rtl/smf_pkg.sv @@
// Shared constants, types and command/status structs of the sliding median filter.
`timescale 1ns / 1ps
`default_nettype none
package smf_pkg;
    localparam int SAMPLE_BITS = 24;
    localparam int MAX_HALF    = 31;
    localparam int HALF_W      = 5;
    localparam int WIN_DEPTH   = 2 * MAX_HALF + 1;
    localparam int ADDR_W      = $clog2(WIN_DEPTH);
    localparam int RAM_DEPTH   = 1 << ADDR_W;
    localparam int CNT_W       = 7;
    localparam int RANK_W      = $clog2(WIN_DEPTH + 1);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [ADDR_W-1:0]             t_off;
    typedef logic [HALF_W-1:0]             t_half;
    typedef logic [CNT_W-1:0]              t_count;
    typedef logic [RANK_W-1:0]             t_rank;

    typedef struct packed {
        logic  load;
        logic  load_last;
        t_off  a_off;
        t_off  b_off;
        logic  cnt_clr;
        logic  cnt_en;
        logic  emit;
        logic  emit_last;
    } t_cmd;

    typedef struct packed {
        t_count count;
        t_rank  less;
        t_rank  equal;
        logic   out_free;
    } t_status;
endpackage
`default_nettype wire

@@ rtl/smf_if.sv @@
// Input and output stream interfaces of the sliding median filter.
`timescale 1ns / 1ps
`default_nettype none
interface smf_in_if;
    logic                 valid;
    logic                 ready;
    smf_pkg::t_sample     in_sample;
    logic                 in_last;
    modport source (output valid, output in_sample, output in_last, input ready);
    modport sink   (input valid, input in_sample, input in_last, output ready);
endinterface

interface smf_out_if;
    logic                 valid;
    logic                 ready;
    smf_pkg::t_sample     out_sample;
    logic                 out_last;
    modport source (output valid, output out_sample, output out_last, input ready);
    modport sink   (input valid, input out_sample, input out_last, output ready);
endinterface
`default_nettype wire

@@ rtl/smf_ram.sv @@
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module smf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule
`default_nettype wire

@@ rtl/smf_dp.sv @@
// Datapath: window RAM, write pointer, trace count, rank counters, output register.
`timescale 1ns / 1ps
`default_nettype none
module smf_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire smf_pkg::t_cmd     i_cmd,
    input  wire smf_pkg::t_sample  i_sample,
    output smf_pkg::t_status       o_status,
    smf_out_if.source              o_out
);
    smf_pkg::t_off    r_wp;
    smf_pkg::t_off    n_wp;
    smf_pkg::t_count  r_count;
    smf_pkg::t_rank   r_less;
    smf_pkg::t_rank   r_equal;
    logic             r_bv;
    logic             r_ovalid;
    smf_pkg::t_sample r_odata;
    logic             r_olast;
    logic [smf_pkg::SAMPLE_BITS-1:0] q_a;
    logic [smf_pkg::SAMPLE_BITS-1:0] q_b;
    smf_pkg::t_off    addr_a;
    smf_pkg::t_off    addr_b;

    assign n_wp   = r_wp + smf_pkg::t_off'(1);
    assign addr_a = r_wp - i_cmd.a_off;
    assign addr_b = r_wp - i_cmd.b_off;

    smf_ram #(
        .WIDTH(smf_pkg::SAMPLE_BITS),
        .DEPTH(smf_pkg::RAM_DEPTH)
    ) u_win (
        .i_clk     (i_clk),
        .i_we      (i_cmd.load),
        .i_waddr   (n_wp),
        .i_wdata   (i_sample),
        .i_raddr_a (addr_a),
        .i_raddr_b (addr_b),
        .o_rdata_a (q_a),
        .o_rdata_b (q_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_count  <= '0;
            r_bv     <= 1'b0;
            r_less   <= '0;
            r_equal  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_bv <= i_cmd.cnt_en;
            if (i_cmd.load) begin
                r_wp <= n_wp;
                if (i_cmd.load_last) begin
                    r_count <= '0;
                end else if (r_count != '1) begin
                    r_count <= r_count + smf_pkg::t_count'(1);
                end
            end
            if (i_cmd.cnt_clr) begin
                r_less  <= '0;
                r_equal <= '0;
            end else if (r_bv) begin
                if ($signed(q_b) < $signed(q_a)) begin
                    r_less <= r_less + smf_pkg::t_rank'(1);
                end else if (q_b == q_a) begin
                    r_equal <= r_equal + smf_pkg::t_rank'(1);
                end
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_odata <= q_a;
            r_olast <= i_cmd.emit_last;
        end
    end

    assign o_status.count    = r_count;
    assign o_status.less     = r_less;
    assign o_status.equal    = r_equal;
    assign o_status.out_free = !r_ovalid || o_out.ready;

    assign o_out.valid      = r_ovalid;
    assign o_out.out_sample = r_odata;
    assign o_out.out_last   = r_olast;
endmodule
`default_nettype wire

@@ rtl/smf_ctrl.sv @@
// Controller: sequences window load, rank search, output and tail flush.
`timescale 1ns / 1ps
`default_nettype none
module smf_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire smf_pkg::t_half    i_half,
    input  wire logic              i_valid,
    input  wire logic              i_last,
    output logic                   o_ready,
    input  wire smf_pkg::t_status  i_status,
    output smf_pkg::t_cmd          o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_MED_SCAN, S_MED_WAIT, S_MED_CHK,
        S_RD, S_EMIT, S_FL_RD, S_FL_EMIT
    } t_state;

    t_state          r_state;
    smf_pkg::t_half  r_h;
    smf_pkg::t_count r_n;
    logic            r_last;
    smf_pkg::t_off   r_aoff;
    smf_pkg::t_off   r_j;
    smf_pkg::t_off   span;
    smf_pkg::t_off   in_span;
    smf_pkg::t_off   fl_start;
    logic            accept;
    logic            med_hit;
    logic [smf_pkg::RANK_W:0] rank_hi;

    assign accept  = i_valid && (r_state == S_IDLE);
    assign o_ready = (r_state == S_IDLE);
    assign span    = {r_h, 1'b0};
    assign in_span = {i_half, 1'b0};
    assign rank_hi = {1'b0, i_status.less} + {1'b0, i_status.equal};
    assign med_hit = (i_status.less <= smf_pkg::t_rank'(r_h))
                  && ((smf_pkg::RANK_W+1)'(r_h) < rank_hi);
    // Flush starts at the oldest pending sample: min(n, h-1).
    assign fl_start = (r_n < smf_pkg::t_count'(r_h - smf_pkg::t_half'(1)))
                    ? smf_pkg::t_off'(r_n)
                    : smf_pkg::t_off'(r_h - smf_pkg::t_half'(1));

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = accept;
        o_cmd.load_last = i_last;
        o_cmd.a_off     = r_aoff;
        o_cmd.b_off     = r_j;
        unique case (r_state)
            S_MED_SCAN: o_cmd.cnt_en = 1'b1;
            // Clear the rank counters after every check so each candidate starts at zero.
            S_MED_CHK:  o_cmd.cnt_clr = 1'b1;
            S_EMIT: begin
                o_cmd.emit      = i_status.out_free;
                o_cmd.emit_last = r_last && (r_h == '0);
            end
            S_FL_EMIT: begin
                o_cmd.emit      = i_status.out_free;
                o_cmd.emit_last = (r_aoff == '0);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_h     <= '0;
            r_n     <= '0;
            r_last  <= 1'b0;
            r_aoff  <= '0;
            r_j     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_h    <= i_half;
                        r_n    <= i_status.count;
                        r_last <= i_last;
                        r_j    <= '0;
                        if (i_status.count >= smf_pkg::t_count'(in_span)) begin
                            r_aoff  <= '0;
                            r_state <= S_MED_SCAN;
                        end else if (i_status.count >= smf_pkg::t_count'(i_half)) begin
                            r_aoff  <= smf_pkg::t_off'(i_half);
                            r_state <= S_RD;
                        end else if (i_last) begin
                            // Short trace so far: h > n >= 0, flush from entry n.
                            r_aoff  <= smf_pkg::t_off'(i_status.count);
                            r_state <= S_FL_RD;
                        end
                    end
                end
                S_MED_SCAN: begin
                    if (r_j == span) begin
                        r_state <= S_MED_WAIT;
                    end else begin
                        r_j <= r_j + smf_pkg::t_off'(1);
                    end
                end
                S_MED_WAIT: r_state <= S_MED_CHK;
                S_MED_CHK: begin
                    if (med_hit) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_aoff  <= r_aoff + smf_pkg::t_off'(1);
                        r_j     <= '0;
                        r_state <= S_MED_SCAN;
                    end
                end
                S_RD: r_state <= S_EMIT;
                S_EMIT: begin
                    if (i_status.out_free) begin
                        if (r_last && (r_h != '0)) begin
                            r_aoff  <= fl_start;
                            r_state <= S_FL_RD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_FL_RD: r_state <= S_FL_EMIT;
                S_FL_EMIT: begin
                    if (i_status.out_free) begin
                        if (r_aoff == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_aoff  <= r_aoff - smf_pkg::t_off'(1);
                            r_state <= S_FL_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/sliding_median_filter_top.sv @@
// Top level of the sliding median filter: config register, controller, datapath.
`timescale 1ns / 1ps
`default_nettype none
// Running median over an odd window of 2h+1 signed 24-bit samples, h set by
// the half-width register (reset 1, write only while idle). Output lags input
// by h samples; the first and last h samples of a trace pass through, and a
// transfer with in_last flushes the pending tail and marks its final output.
// One sample is handled at a time. A sample that completes a full window
// runs an exact rank search through the two-read-port window RAM: each
// candidate scans all 2h+1 entries, at worst every entry is tried as the
// candidate, and on typical data, where the median is found early, far
// fewer are. An edge sample that passes through goes through a read and an
// emit state, a sample with no output is only loaded, and each flushed tail
// sample has its own read and emit states; a stalled output register holds
// the emit state until it frees. The output register lets a new input
// transfer be taken while the last result still waits downstream.
module sliding_median_filter_top (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire smf_pkg::t_half  i_cfg_data,
    smf_in_if.sink               i_in,
    smf_out_if.source            o_out
);
    smf_pkg::t_half   r_half_width;
    smf_pkg::t_cmd    cmd;
    smf_pkg::t_status status;

    // Hold the half width; a write takes effect from the next accepted sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= smf_pkg::t_half'(1);
        end else if (i_cfg_we) begin
            r_half_width <= i_cfg_data;
        end
    end

    smf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_half   (r_half_width),
        .i_valid  (i_in.valid),
        .i_last   (i_in.in_last),
        .o_ready  (i_in.ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    smf_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_sample (i_in.in_sample),
        .o_status (status),
        .o_out    (o_out)
    );
endmodule
`default_nettype wire
